### rtl/tmse_pkg.sv
// ----------------------------------------------------------------------------
// tmse_pkg
// Shared widths, codes and types of the Turing machine step engine.
// ----------------------------------------------------------------------------
package tmse_pkg;

   localparam int ACT_W   = 3;
   localparam int STATE_W = 4;
   localparam int SYM_W   = 8;
   localparam int CELL_W  = 10;
   localparam int STEP_W  = 32;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam int DEF_STATE_COUNT = 16;
   localparam int DEF_TAPE_DEPTH  = 1024;

   localparam logic [SYM_W-1:0] BLANK_SYM = 8'd95;

   // item actions
   localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_STEP    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RESTART = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ    = 3'd4;

   // register indexes
   localparam logic [1:0] REG_START  = 2'd0;
   localparam logic [1:0] REG_ACCEPT = 2'd1;
   localparam logic [1:0] REG_REJECT = 2'd2;

   typedef struct packed {
      logic [STATE_W-1:0] start_state;
      logic [STATE_W-1:0] accept_state;
      logic [STATE_W-1:0] reject_state;
   } cfg_type;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [STATE_W-1:0] from_state;
      logic [SYM_W-1:0]   symbol;
      logic [STATE_W-1:0] next_state;
      logic [SYM_W-1:0]   out_symbol;
      logic               move_right;
      logic [CELL_W-1:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic [STATE_W-1:0] state_now;
      logic [CELL_W-1:0]  head_now;
      logic               halted;
      logic               accepted;
      logic [STEP_W-1:0]  steps_taken;
      logic [SYM_W-1:0]   read_symbol;
      logic               tape_end;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [STATE_W-1:0] next_state;
      logic [SYM_W-1:0]   out_symbol;
      logic               move_right;
   } trans_entry_type;

   localparam int TRANS_W = $bits(trans_entry_type);

endpackage

### rtl/tmse_if.sv
// ----------------------------------------------------------------------------
// tmse_if
// Valid/ready channels for request and result items.
// ----------------------------------------------------------------------------
interface tmse_req_if;
   logic                        valid;
   logic                        ready;
   logic [tmse_pkg::ACT_W-1:0]   action;
   logic [tmse_pkg::STATE_W-1:0] from_state;
   logic [tmse_pkg::SYM_W-1:0]   symbol;
   logic [tmse_pkg::STATE_W-1:0] next_state;
   logic [tmse_pkg::SYM_W-1:0]   out_symbol;
   logic                        move_right;
   logic [tmse_pkg::CELL_W-1:0]  cell_index;

   modport source (output valid, action, from_state, symbol, next_state, out_symbol,
                   move_right, cell_index, input ready);
   modport sink   (input valid, action, from_state, symbol, next_state, out_symbol,
                   move_right, cell_index, output ready);
endinterface

interface tmse_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tmse_pkg::STATE_W-1:0] state_now;
   logic [tmse_pkg::CELL_W-1:0]  head_now;
   logic                        halted;
   logic                        accepted;
   logic [tmse_pkg::STEP_W-1:0]  steps_taken;
   logic [tmse_pkg::SYM_W-1:0]   read_symbol;
   logic                        tape_end;

   modport source (output valid, state_now, head_now, halted, accepted, steps_taken,
                   read_symbol, tape_end, input ready);
   modport sink   (input valid, state_now, head_now, halted, accepted, steps_taken,
                   read_symbol, tape_end, output ready);
endinterface

### rtl/tmse_ram.sv
// ----------------------------------------------------------------------------
// tmse_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tmse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/tmse_csr.sv
// ----------------------------------------------------------------------------
// tmse_csr
// APB register file: start, accept and reject state.
// ----------------------------------------------------------------------------
module tmse_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tmse_pkg::CSR_AW-1:0]   paddr,
   input  logic [tmse_pkg::CSR_DW-1:0]   pwdata,
   output logic [tmse_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready,
   output tmse_pkg::cfg_type             cfg
);

   logic [tmse_pkg::STATE_W-1:0] start_ff, start_in;
   logic [tmse_pkg::STATE_W-1:0] accept_ff, accept_in;
   logic [tmse_pkg::STATE_W-1:0] reject_ff, reject_in;
   logic [1:0]                   idx;
   logic                         wr;

   assign idx    = paddr[3:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      start_in  = start_ff;
      accept_in = accept_ff;
      reject_in = reject_ff;
      if (wr) begin
         unique case (idx)
            tmse_pkg::REG_START:  start_in  = pwdata[tmse_pkg::STATE_W-1:0];
            tmse_pkg::REG_ACCEPT: accept_in = pwdata[tmse_pkg::STATE_W-1:0];
            tmse_pkg::REG_REJECT: reject_in = pwdata[tmse_pkg::STATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         tmse_pkg::REG_START:  prdata = tmse_pkg::CSR_DW'(start_ff);
         tmse_pkg::REG_ACCEPT: prdata = tmse_pkg::CSR_DW'(accept_ff);
         tmse_pkg::REG_REJECT: prdata = tmse_pkg::CSR_DW'(reject_ff);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= 4'd0;
         accept_ff <= 4'd1;
         reject_ff <= 4'd2;
      end else begin
         start_ff  <= start_in;
         accept_ff <= accept_in;
         reject_ff <= reject_in;
      end
   end

   assign cfg.start_state  = start_ff;
   assign cfg.accept_state = accept_ff;
   assign cfg.reject_state = reject_ff;

endmodule

### rtl/tmse_ctrl.sv
// ----------------------------------------------------------------------------
// tmse_ctrl
// Sequencer: clearing pass, item decode, step read-modify-write, result register.
// ----------------------------------------------------------------------------
module tmse_ctrl #(
   parameter int STATE_COUNT = tmse_pkg::DEF_STATE_COUNT,
   parameter int TAPE_DEPTH  = tmse_pkg::DEF_TAPE_DEPTH,
   localparam int SIW = $clog2(STATE_COUNT),
   localparam int TAW = SIW + tmse_pkg::SYM_W,
   localparam int HW  = $clog2(TAPE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tmse_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   input  tmse_pkg::req_type             req_data,
   output logic                          req_ready,
   output logic                          rsp_valid,
   output tmse_pkg::rsp_type             rsp_data,
   input  logic                          rsp_ready,
   output logic                          t_we,
   output logic [TAW-1:0]                t_waddr,
   output logic [tmse_pkg::TRANS_W-1:0]  t_wdata,
   output logic                          t_re,
   output logic [TAW-1:0]                t_raddr,
   input  logic [tmse_pkg::TRANS_W-1:0]  t_rdata,
   output logic                          p_we,
   output logic [HW-1:0]                 p_waddr,
   output logic [tmse_pkg::SYM_W-1:0]    p_wdata,
   output logic                          p_re,
   output logic [HW-1:0]                 p_raddr,
   input  logic [tmse_pkg::SYM_W-1:0]    p_rdata
);

   localparam int TS_DEPTH = STATE_COUNT * 256;
   localparam int CLR_LEN  = (TS_DEPTH > TAPE_DEPTH) ? TS_DEPTH : TAPE_DEPTH;
   localparam int CW       = $clog2(CLR_LEN);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_TRW  = 3'd2;
   localparam logic [2:0] S_RDW  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [CW-1:0]                clr_cnt_ff, clr_cnt_in;
   logic [tmse_pkg::STATE_W-1:0] mstate_ff, mstate_in;
   logic [HW-1:0]                head_ff, head_in;
   logic [tmse_pkg::STEP_W-1:0]  steps_ff, steps_in;
   logic                         end_ff, end_in;
   logic [tmse_pkg::SYM_W-1:0]   hsym_ff, hsym_in;    // mirrors tape cell under head
   logic [tmse_pkg::SYM_W-1:0]   rsym_ff, rsym_in;
   logic                         is_rd_ff, is_rd_in;
   logic                         miss_ff, miss_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   tmse_pkg::rsp_type            rsp_ff, rsp_in;

   tmse_pkg::trans_entry_type    ent;
   logic                         hit;
   logic [tmse_pkg::STATE_W-1:0] nxt_st;
   logic [tmse_pkg::SYM_W-1:0]   wsym;
   logic                         go_right;
   logic                         clamp;
   logic [HW-1:0]                head_new;
   logic                         halted;
   logic                         from_ok;
   logic                         state_ok;
   logic                         cell_ok;
   logic                         is_head;

   assign halted   = (mstate_ff == cfg.accept_state) || (mstate_ff == cfg.reject_state);
   assign from_ok  = 32'(req_data.from_state) < 32'(STATE_COUNT);
   assign state_ok = 32'(mstate_ff) < 32'(STATE_COUNT);
   assign cell_ok  = 32'(req_data.cell_index) < 32'(TAPE_DEPTH);
   assign is_head  = 32'(req_data.cell_index) == 32'(head_ff);

   // transition decode; a missing entry sends to reject, rewrites, moves left
   always_comb begin
      ent      = tmse_pkg::trans_entry_type'(t_rdata);
      hit      = ent.valid && !miss_ff;
      nxt_st   = hit ? ent.next_state : cfg.reject_state;
      wsym     = hit ? ent.out_symbol : hsym_ff;
      go_right = hit && ent.move_right;
      clamp    = 1'b0;
      head_new = head_ff;
      if (go_right) begin
         if (head_ff == HW'(TAPE_DEPTH - 1)) begin
            clamp = 1'b1;
         end else begin
            head_new = head_ff + 1'b1;
         end
      end else if (head_ff != '0) begin
         head_new = head_ff - 1'b1;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      mstate_in    = mstate_ff;
      head_in      = head_ff;
      steps_in     = steps_ff;
      end_in       = end_ff;
      hsym_in      = hsym_ff;
      rsym_in      = rsym_ff;
      is_rd_in     = is_rd_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      t_we    = 1'b0;
      t_waddr = '0;
      t_wdata = '0;
      t_re    = 1'b0;
      t_raddr = '0;
      p_we    = 1'b0;
      p_waddr = '0;
      p_wdata = tmse_pkg::BLANK_SYM;
      p_re    = 1'b0;
      p_raddr = '0;

      unique case (state_ff)
         S_CLR: begin
            t_we       = 32'(clr_cnt_ff) < 32'(TS_DEPTH);
            t_waddr    = TAW'(clr_cnt_ff);
            p_we       = 32'(clr_cnt_ff) < 32'(TAPE_DEPTH);
            p_waddr    = HW'(clr_cnt_ff);
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CW'(CLR_LEN - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               is_rd_in = 1'b0;
               state_in = S_FIN;
               unique case (req_data.action)
                  tmse_pkg::ACT_LOAD: begin
                     t_we    = from_ok;
                     t_waddr = {SIW'(req_data.from_state), req_data.symbol};
                     t_wdata = {1'b1, req_data.next_state, req_data.out_symbol,
                                req_data.move_right};
                  end
                  tmse_pkg::ACT_WRITE: begin
                     p_we    = cell_ok;
                     p_waddr = HW'(req_data.cell_index);
                     p_wdata = req_data.symbol;
                     if (cell_ok && is_head) begin
                        hsym_in = req_data.symbol;
                     end
                  end
                  tmse_pkg::ACT_STEP: begin
                     if (!halted) begin
                        miss_in  = !state_ok;
                        t_re     = 1'b1;
                        t_raddr  = {SIW'(mstate_ff), hsym_ff};
                        state_in = S_TRW;
                     end
                  end
                  tmse_pkg::ACT_RESTART: begin
                     mstate_in = cfg.start_state;
                     head_in   = '0;
                     steps_in  = '0;
                     end_in    = 1'b0;
                     p_re      = 1'b1;
                     state_in  = S_RDW;
                  end
                  tmse_pkg::ACT_READ: begin
                     is_rd_in = 1'b1;
                     if (cell_ok) begin
                        p_re     = 1'b1;
                        p_raddr  = HW'(req_data.cell_index);
                        state_in = S_RDW;
                     end else begin
                        rsym_in = tmse_pkg::BLANK_SYM;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TRW: begin
            p_we      = 1'b1;
            p_waddr   = head_ff;
            p_wdata   = wsym;
            mstate_in = nxt_st;
            head_in   = head_new;
            end_in    = end_ff || clamp;
            steps_in  = (steps_ff == '1) ? steps_ff : steps_ff + 1'b1;
            if (head_new != head_ff) begin
               p_re     = 1'b1;
               p_raddr  = head_new;
               state_in = S_RDW;
            end else begin
               // head stayed: the cell just written is under it
               hsym_in  = wsym;
               state_in = S_FIN;
            end
         end
         S_RDW: begin
            if (is_rd_ff) begin
               rsym_in = p_rdata;
            end else begin
               hsym_in = p_rdata;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.state_now   = mstate_ff;
               rsp_in.head_now    = tmse_pkg::CELL_W'(head_ff);
               rsp_in.halted      = halted;
               rsp_in.accepted    = (mstate_ff == cfg.accept_state);
               rsp_in.steps_taken = steps_ff;
               rsp_in.read_symbol = is_rd_ff ? rsym_ff : hsym_ff;
               rsp_in.tape_end    = end_ff;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         mstate_ff    <= '0;
         head_ff      <= '0;
         steps_ff     <= '0;
         end_ff       <= 1'b0;
         hsym_ff      <= tmse_pkg::BLANK_SYM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         mstate_ff    <= mstate_in;
         head_ff      <= head_in;
         steps_ff     <= steps_in;
         end_ff       <= end_in;
         hsym_ff      <= hsym_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsym_ff  <= rsym_in;
      is_rd_ff <= is_rd_in;
      miss_ff  <= miss_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/turing_machine_step_engine_core.sv
// Path, input accept to result: load, tape write, unknown action, a step while halted and a
// read past the tape go from idle straight to S_FIN; restart and an in-range tape read pass
// through S_RDW, a step whose head stays put through S_TRW, a step that moves the head through
// S_TRW then S_RDW. One item in flight; the next item is taken once the result register loads.
// Synchronous reset, then a clearing pass over max(STATE_COUNT*256, TAPE_DEPTH) addresses
// (4096 by default) with req_ch.ready low.
// ----------------------------------------------------------------------------
// turing_machine_step_engine_core
// Single-tape Turing machine engine with transition and tape RAMs.
// ----------------------------------------------------------------------------
module turing_machine_step_engine_core #(
   parameter int STATE_COUNT = tmse_pkg::DEF_STATE_COUNT,
   parameter int TAPE_DEPTH  = tmse_pkg::DEF_TAPE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   tmse_req_if.sink                    req_ch,
   tmse_rsp_if.source                  rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tmse_pkg::CSR_AW-1:0] paddr,
   input  logic [tmse_pkg::CSR_DW-1:0] pwdata,
   output logic [tmse_pkg::CSR_DW-1:0] prdata,
   output logic                        pready
);

   localparam int SIW      = $clog2(STATE_COUNT);
   localparam int TAW      = SIW + tmse_pkg::SYM_W;
   localparam int HW       = $clog2(TAPE_DEPTH);
   localparam int TS_DEPTH = STATE_COUNT * 256;

   tmse_pkg::cfg_type                cfg;
   tmse_pkg::req_type                req_data;
   tmse_pkg::rsp_type                rsp_data;
   logic                             t_we, t_re;
   logic [TAW-1:0]                   t_waddr, t_raddr;
   logic [tmse_pkg::TRANS_W-1:0]     t_wdata, t_rdata;
   logic                             p_we, p_re;
   logic [HW-1:0]                    p_waddr, p_raddr;
   logic [tmse_pkg::SYM_W-1:0]       p_wdata, p_rdata;

   assign req_data.action     = req_ch.action;
   assign req_data.from_state = req_ch.from_state;
   assign req_data.symbol     = req_ch.symbol;
   assign req_data.next_state = req_ch.next_state;
   assign req_data.out_symbol = req_ch.out_symbol;
   assign req_data.move_right = req_ch.move_right;
   assign req_data.cell_index = req_ch.cell_index;

   assign rsp_ch.state_now   = rsp_data.state_now;
   assign rsp_ch.head_now    = rsp_data.head_now;
   assign rsp_ch.halted      = rsp_data.halted;
   assign rsp_ch.accepted    = rsp_data.accepted;
   assign rsp_ch.steps_taken = rsp_data.steps_taken;
   assign rsp_ch.read_symbol = rsp_data.read_symbol;
   assign rsp_ch.tape_end    = rsp_data.tape_end;

   tmse_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tmse_ram #(
      .WIDTH (tmse_pkg::TRANS_W),
      .DEPTH (TS_DEPTH),
      .AW    (TAW)
   ) u_trans_ram (
      .clock (clock),
      .we    (t_we),
      .waddr (t_waddr),
      .wdata (t_wdata),
      .re    (t_re),
      .raddr (t_raddr),
      .rdata (t_rdata)
   );

   tmse_ram #(
      .WIDTH (tmse_pkg::SYM_W),
      .DEPTH (TAPE_DEPTH),
      .AW    (HW)
   ) u_tape_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .re    (p_re),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

   tmse_ctrl #(
      .STATE_COUNT (STATE_COUNT),
      .TAPE_DEPTH  (TAPE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_ch.valid),
      .req_data  (req_data),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ch.ready),
      .t_we      (t_we),
      .t_waddr   (t_waddr),
      .t_wdata   (t_wdata),
      .t_re      (t_re),
      .t_raddr   (t_raddr),
      .t_rdata   (t_rdata),
      .p_we      (p_we),
      .p_waddr   (p_waddr),
      .p_wdata   (p_wdata),
      .p_re      (p_re),
      .p_raddr   (p_raddr),
      .p_rdata   (p_rdata)
   );

`ifndef ASSERT_OFF
   // one item at a time: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("item accepted while previous item in flight");

   // clearing pass holds off items after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ch.ready)
      else $error("item port open during clearing pass");

   a_accept_implies_halt: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.accepted) |-> rsp_ch.halted)
      else $error("accepted result not flagged halted");

   a_head_in_tape: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (32'(rsp_ch.head_now) < 32'(TAPE_DEPTH)))
      else $error("head position beyond tape");
`endif

endmodule

### dv/turing_machine_step_engine_core_test.sv
// ----------------------------------------------------------------------------
// turing_machine_step_engine_core_test
// Self-checking bench for the Turing machine step engine. A directed part covers
// field extremes, every action and the halting and left clamping corner cases.
// Random machine runs follow: small programs with random content, mixed with
// noise items. Every result is checked against a behavioral tracker of the
// machine, under random valid/ready idling.
// ----------------------------------------------------------------------------
module turing_machine_step_engine_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_STATES      = tmse_pkg::DEF_STATE_COUNT;
   localparam int TAPE_CELLS    = tmse_pkg::DEF_TAPE_DEPTH;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 20000;
   localparam int CHUNK_ITEMS   = 234;

   // actions the block ignores
   localparam logic [tmse_pkg::ACT_W-1:0] ACT_BAD_FIRST = 3'd5;
   localparam logic [tmse_pkg::ACT_W-1:0] ACT_BAD_MID   = 3'd6;
   localparam logic [tmse_pkg::ACT_W-1:0] ACT_BAD_LAST  = 3'd7;
   // register index past the end of the map
   localparam logic [1:0] REG_NONE = 2'd3;

   // Tracks machine state and holds the expected status of each accepted item.
   class machine_tracker;
      tmse_pkg::cfg_type            regs;
      tmse_pkg::trans_entry_type    rules [N_STATES*256];
      logic [tmse_pkg::SYM_W-1:0]   tape [TAPE_CELLS];
      logic [tmse_pkg::STATE_W-1:0] state;
      logic [tmse_pkg::CELL_W-1:0]  head;
      logic [tmse_pkg::STEP_W-1:0]  steps;
      logic                         end_flag;
      tmse_pkg::rsp_type            expected_q [$];
      int                           errors;
      int                           checked;
      int                           accept_seen;
      int                           end_seen;
      int                           action_hits [8];

      function new();
         regs = '{start_state: 4'd0, accept_state: 4'd1, reject_state: 4'd2};
         foreach (rules[i]) rules[i] = '0;
         foreach (tape[i]) tape[i] = tmse_pkg::BLANK_SYM;
         foreach (action_hits[i]) action_hits[i] = 0;
         state = '0;
         head = '0;
         steps = '0;
         end_flag = 1'b0;
         errors = 0;
         checked = 0;
         accept_seen = 0;
         end_seen = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [tmse_pkg::STATE_W-1:0] val);
         case (idx)
            tmse_pkg::REG_START:  regs.start_state = val;
            tmse_pkg::REG_ACCEPT: regs.accept_state = val;
            tmse_pkg::REG_REJECT: regs.reject_state = val;
            default: ;
         endcase
      endfunction

      function bit is_halted();
         return state == regs.accept_state || state == regs.reject_state;
      endfunction

      function void take_step();
         int                        sym;
         tmse_pkg::trans_entry_type ent;
         logic                      right;
         if (is_halted()) return;
         sym = int'(tape[head]);
         ent = '0;
         if (int'(state) < N_STATES) ent = rules[int'(state)*256 + sym];
         // missing rule: reject, keep the symbol, go left
         if (ent.valid) begin
            state = ent.next_state;
            tape[head] = ent.out_symbol;
            right = ent.move_right;
         end else begin
            state = regs.reject_state;
            right = 1'b0;
         end
         if (right) begin
            if (int'(head) + 1 < TAPE_CELLS) head = head + 1'b1;
            else end_flag = 1'b1;
         end else if (head != '0) begin
            head = head - 1'b1;
         end
         if (steps != '1) steps = steps + 1'b1;
      endfunction

      function void note_item(tmse_pkg::req_type r);
         tmse_pkg::rsp_type e;
         action_hits[r.action]++;
         case (r.action)
            tmse_pkg::ACT_LOAD: begin
               if (int'(r.from_state) < N_STATES)
                  rules[int'(r.from_state)*256 + int'(r.symbol)] =
                     '{valid: 1'b1, next_state: r.next_state,
                       out_symbol: r.out_symbol, move_right: r.move_right};
            end
            tmse_pkg::ACT_WRITE: begin
               if (int'(r.cell_index) < TAPE_CELLS) tape[r.cell_index] = r.symbol;
            end
            tmse_pkg::ACT_STEP: take_step();
            tmse_pkg::ACT_RESTART: begin
               state = regs.start_state;
               head = '0;
               steps = '0;
               end_flag = 1'b0;
            end
            default: ;
         endcase
         e.state_now   = state;
         e.head_now    = head;
         e.halted      = is_halted();
         e.accepted    = state == regs.accept_state;
         e.steps_taken = steps;
         if (r.action == tmse_pkg::ACT_READ)
            e.read_symbol = (int'(r.cell_index) < TAPE_CELLS) ? tape[r.cell_index]
                                                             : tmse_pkg::BLANK_SYM;
         else
            e.read_symbol = tape[head];
         e.tape_end    = end_flag;
         expected_q.push_back(e);
      endfunction

      function string show(tmse_pkg::rsp_type x);
         return $sformatf("state %0d head %0d halted %0b accepted %0b steps %0d sym %0d end %0b",
                          x.state_now, x.head_now, x.halted, x.accepted, x.steps_taken,
                          x.read_symbol, x.tape_end);
      endfunction

      function void fail_note(string what);
         errors++;
         if (errors <= 10) $display("[%0t] %s", $time, what);
      endfunction

      function void check_result(tmse_pkg::rsp_type got);
         tmse_pkg::rsp_type e;
         string             diff;
         checked++;
         if (got.accepted === 1'b1) accept_seen++;
         if (got.tape_end === 1'b1) end_seen++;
         if (expected_q.size() == 0) begin
            fail_note($sformatf("result %0d with nothing outstanding: %s", checked, show(got)));
            return;
         end
         e = expected_q.pop_front();
         diff = "";
         if (got.state_now !== e.state_now) diff = {diff, " state_now"};
         if (got.head_now !== e.head_now) diff = {diff, " head_now"};
         if (got.halted !== e.halted) diff = {diff, " halted"};
         if (got.accepted !== e.accepted) diff = {diff, " accepted"};
         if (got.steps_taken !== e.steps_taken) diff = {diff, " steps_taken"};
         if (got.read_symbol !== e.read_symbol) diff = {diff, " read_symbol"};
         if (got.tape_end !== e.tape_end) diff = {diff, " tape_end"};
         if (diff != "")
            fail_note($sformatf("result %0d bad%s\n   expected %s\n   actual   %s",
                                checked, diff, show(e), show(got)));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [tmse_pkg::CSR_AW-1:0] paddr;
   logic [tmse_pkg::CSR_DW-1:0] pwdata;
   logic [tmse_pkg::CSR_DW-1:0] prdata;
   logic                        pready;

   tmse_req_if req_ch ();
   tmse_rsp_if rsp_ch ();

   machine_tracker board;
   int send_idle_pct;
   int recv_idle_pct;
   int useful_items;
   int reg_writes;
   int quiet_cycles;

   turing_machine_step_engine_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result({rsp_ch.state_now, rsp_ch.head_now, rsp_ch.halted,
                             rsp_ch.accepted, rsp_ch.steps_taken, rsp_ch.read_symbol,
                             rsp_ch.tape_end});
   end

   // nothing accepted for too long: hung
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
                  quiet_cycles, board.pending());
         $display("turing_machine_step_engine_core_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic tmse_pkg::req_type noise_item();
      tmse_pkg::req_type r;
      r.action     = tmse_pkg::ACT_W'($urandom_range(0, 7));
      r.from_state = tmse_pkg::STATE_W'($urandom_range(0, 15));
      r.symbol     = tmse_pkg::SYM_W'($urandom_range(0, 255));
      r.next_state = tmse_pkg::STATE_W'($urandom_range(0, 15));
      r.out_symbol = tmse_pkg::SYM_W'($urandom_range(0, 255));
      r.move_right = 1'($urandom_range(0, 1));
      r.cell_index = tmse_pkg::CELL_W'($urandom_range(0, 1023));
      return r;
   endfunction

   function automatic tmse_pkg::req_type mk(logic [tmse_pkg::ACT_W-1:0] act,
                                            logic [tmse_pkg::STATE_W-1:0] from,
                                            logic [tmse_pkg::SYM_W-1:0] sym,
                                            logic [tmse_pkg::STATE_W-1:0] nxt,
                                            logic [tmse_pkg::SYM_W-1:0] osym, logic right,
                                            logic [tmse_pkg::CELL_W-1:0] cell_idx);
      tmse_pkg::req_type r;
      r.action     = act;
      r.from_state = from;
      r.symbol     = sym;
      r.next_state = nxt;
      r.out_symbol = osym;
      r.move_right = right;
      r.cell_index = cell_idx;
      return r;
   endfunction

   // called just after a falling edge; returns just after a falling edge
   task automatic send_item(tmse_pkg::req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= r.action;
      req_ch.from_state <= r.from_state;
      req_ch.symbol     <= r.symbol;
      req_ch.next_state <= r.next_state;
      req_ch.out_symbol <= r.out_symbol;
      req_ch.move_right <= r.move_right;
      req_ch.cell_index <= r.cell_index;
      do @(posedge clock); while (!req_ch.ready);
      board.note_item(r);
      if (r.action <= tmse_pkg::ACT_READ) useful_items++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [tmse_pkg::STATE_W-1:0] val);
      logic [tmse_pkg::CSR_DW-1:0] data;
      data = $urandom;
      data[tmse_pkg::STATE_W-1:0] = val;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      board.set_reg(idx, val);
      reg_writes++;
   endtask

   task automatic set_machine(logic [tmse_pkg::STATE_W-1:0] start,
                              logic [tmse_pkg::STATE_W-1:0] acc,
                              logic [tmse_pkg::STATE_W-1:0] rej);
      wait_for_results();
      write_reg(tmse_pkg::REG_START, start);
      write_reg(tmse_pkg::REG_ACCEPT, acc);
      write_reg(tmse_pkg::REG_REJECT, rej);
   endtask

   task automatic pick_config();
      case ($urandom_range(0, 5))
         0: set_machine(4'd0, 4'd0, 4'd0);
         1: set_machine(4'd15, 4'd15, 4'd15);
         default: set_machine(tmse_pkg::STATE_W'($urandom_range(0, 15)),
                              tmse_pkg::STATE_W'($urandom_range(0, 15)),
                              tmse_pkg::STATE_W'($urandom_range(0, 15)));
      endcase
   endtask

   function automatic logic [tmse_pkg::STATE_W-1:0] near_start();
      return tmse_pkg::STATE_W'(board.regs.start_state + $urandom_range(0, 3));
   endfunction

   // small random machine over a three-symbol alphabet, then restart and run it
   task automatic run_program();
      logic [tmse_pkg::SYM_W-1:0] alpha [3];
      tmse_pkg::req_type          r;
      int                         n;
      int                         i;
      alpha[0] = tmse_pkg::BLANK_SYM;
      alpha[1] = tmse_pkg::SYM_W'($urandom_range(0, 255));
      alpha[2] = tmse_pkg::SYM_W'($urandom_range(0, 255));
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++) begin
         r = noise_item();
         r.action = tmse_pkg::ACT_WRITE;
         r.cell_index = tmse_pkg::CELL_W'(i);
         r.symbol = alpha[$urandom_range(0, 2)];
         send_item(r);
      end
      n = $urandom_range(3, 10);
      for (i = 0; i < n; i++) begin
         r = noise_item();
         r.action = tmse_pkg::ACT_LOAD;
         r.from_state = near_start();
         r.symbol = alpha[$urandom_range(0, 2)];
         r.out_symbol = alpha[$urandom_range(0, 2)];
         case ($urandom_range(0, 5))
            0: r.next_state = board.regs.accept_state;
            1: r.next_state = board.regs.reject_state;
            default: r.next_state = near_start();
         endcase
         send_item(r);
      end
      r = noise_item();
      r.action = tmse_pkg::ACT_RESTART;
      send_item(r);
      n = $urandom_range(1, 16);
      for (i = 0; i < n; i++) begin
         r = noise_item();
         r.action = tmse_pkg::ACT_STEP;
         send_item(r);
      end
      n = $urandom_range(0, 2);
      for (i = 0; i < n; i++) begin
         r = noise_item();
         r.action = tmse_pkg::ACT_READ;
         r.cell_index = tmse_pkg::CELL_W'($urandom_range(0, 7));
         send_item(r);
      end
   endtask

   task automatic run_chunk();
      int mark;
      int pick;
      mark = useful_items;
      while (useful_items - mark < CHUNK_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) pick_config();
         else if (pick < 14) wait_for_results();
         else if (pick < 34) repeat ($urandom_range(1, 5)) send_item(noise_item());
         else run_program();
      end
   endtask

   initial begin
      board = new();
      send_idle_pct = 28;
      recv_idle_pct = 81;
      useful_items = 0;
      reg_writes = 0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.action = '0;
      req_ch.from_state = '0;
      req_ch.symbol = '0;
      req_ch.next_state = '0;
      req_ch.out_symbol = '0;
      req_ch.move_right = 1'b0;
      req_ch.cell_index = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_machine(4'd0, 4'd1, 4'd2);
      write_reg(REG_NONE, 4'd9);

      // directed: blank tape, both tape ends, ignored actions
      send_item(mk(tmse_pkg::ACT_READ, '0, '0, '0, '0, 1'b0, 10'd0));
      send_item(mk(tmse_pkg::ACT_READ, '0, '0, '0, '0, 1'b0, 10'd1023));
      send_item(mk(tmse_pkg::ACT_WRITE, '0, 8'hFF, '0, '0, 1'b0, 10'd1023));
      send_item(mk(tmse_pkg::ACT_READ, '0, '0, '0, '0, 1'b0, 10'd1023));
      send_item(mk(tmse_pkg::ACT_WRITE, '0, 8'h00, '0, '0, 1'b0, 10'd0));
      send_item(mk(ACT_BAD_FIRST, 4'd15, 8'hFF, 4'd15, 8'hFF, 1'b1, 10'd1023));
      send_item(mk(ACT_BAD_MID, '0, '0, '0, '0, 1'b0, '0));
      send_item(mk(ACT_BAD_LAST, '0, '0, '0, '0, 1'b0, '0));
      // no rule: reject, left move clamped at cell zero; then a step while halted
      send_item(mk(tmse_pkg::ACT_STEP, '0, '0, '0, '0, 1'b0, '0));
      send_item(mk(tmse_pkg::ACT_STEP, '0, '0, '0, '0, 1'b0, '0));
      // three-step machine ending in accept
      send_item(mk(tmse_pkg::ACT_LOAD, 4'd0, 8'h00, 4'd4, 8'hFF, 1'b1, '0));
      send_item(mk(tmse_pkg::ACT_LOAD, 4'd4, tmse_pkg::BLANK_SYM, 4'd15, 8'hFF, 1'b1, '0));
      send_item(mk(tmse_pkg::ACT_LOAD, 4'd15, tmse_pkg::BLANK_SYM, 4'd1, 8'h00, 1'b0, '0));
      send_item(mk(tmse_pkg::ACT_RESTART, '0, '0, '0, '0, 1'b0, '0));
      repeat (4) send_item(mk(tmse_pkg::ACT_STEP, '0, '0, '0, '0, 1'b0, '0));
      send_item(mk(tmse_pkg::ACT_READ, '0, '0, '0, '0, 1'b0, 10'd2));
      // degenerate register settings: start already halted
      set_machine(4'd15, 4'd15, 4'd15);
      send_item(mk(tmse_pkg::ACT_RESTART, '0, '0, '0, '0, 1'b0, '0));
      send_item(mk(tmse_pkg::ACT_STEP, '0, '0, '0, '0, 1'b0, '0));
      set_machine(4'd0, 4'd0, 4'd0);
      send_item(mk(tmse_pkg::ACT_RESTART, '0, '0, '0, '0, 1'b0, '0));
      send_item(mk(tmse_pkg::ACT_STEP, '0, '0, '0, '0, 1'b0, '0));

      set_machine(4'd0, 4'd15, 4'd14);
      run_chunk();

      send_idle_pct = 81;
      recv_idle_pct = 28;
      set_machine(4'd3, 4'd0, 4'd15);
      run_chunk();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      pick_config();
      run_chunk();

      wait_for_results();
      $display("run covered %0d loads, %0d tape writes, %0d steps, %0d restarts, %0d reads",
               board.action_hits[tmse_pkg::ACT_LOAD], board.action_hits[tmse_pkg::ACT_WRITE],
               board.action_hits[tmse_pkg::ACT_STEP], board.action_hits[tmse_pkg::ACT_RESTART],
               board.action_hits[tmse_pkg::ACT_READ]);
      $display("%0d results checked (%0d accepting, %0d at tape end), %0d reg writes, %0d bad",
               board.checked, board.accept_seen, board.end_seen, reg_writes, board.errors);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("turing_machine_step_engine_core_test: clean");
      end else begin
         $display("turing_machine_step_engine_core_test: errors");
      end
      $finish;
   end

endmodule
